FILE: src/jtok_pkg.sv
// ----------------------------------------------------------------------------
// jtok_pkg: shared types and constants for the JSON tokenizer
// Lexer phase codes, token kinds, result record type, helper functions.
// ----------------------------------------------------------------------------
package jtok_pkg;

  localparam int POSITION_BITS = 16;
  localparam int MAX_RESULTS   = 4;
  localparam int CNT_BITS      = 3;

  typedef enum logic [3:0] {
    PH_IDLE        = 4'd0,
    PH_KEYWORD     = 4'd1,
    PH_STRING      = 4'd2,
    PH_ESCAPE      = 4'd3,
    PH_HEX         = 4'd4,
    PH_SURR_BSL    = 4'd5,
    PH_SURR_U      = 4'd6,
    PH_SURR_HEX    = 4'd7,
    PH_NUM_SIGN    = 4'd8,
    PH_NUM_INT     = 4'd9,
    PH_NUM_LEADDOT = 4'd10,
    PH_NUM_FRAC    = 4'd11,
    PH_NUM_EXP     = 4'd12,
    PH_NUM_EXPSIGN = 4'd13,
    PH_NUM_EXPDIG  = 4'd14
  } phase_t;

  localparam logic [3:0] K_LBRACE   = 4'd0;
  localparam logic [3:0] K_RBRACE   = 4'd1;
  localparam logic [3:0] K_LBRACKET = 4'd2;
  localparam logic [3:0] K_RBRACKET = 4'd3;
  localparam logic [3:0] K_COLON    = 4'd4;
  localparam logic [3:0] K_COMMA    = 4'd5;
  localparam logic [3:0] K_STRING   = 4'd6;
  localparam logic [3:0] K_NUMBER   = 4'd7;
  localparam logic [3:0] K_TRUE     = 4'd8;
  localparam logic [3:0] K_FALSE    = 4'd9;
  localparam logic [3:0] K_NULL     = 4'd10;
  localparam logic [3:0] K_EOF      = 4'd11;
  localparam logic [3:0] K_ERROR    = 4'd12;

  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

  typedef struct packed {
    logic [3:0] kind;
    logic       has_byte;
    logic [7:0] data;
    logic       done;
  } res_t;

  // One accepted byte's results, with its position
  typedef struct packed {
    res_t [MAX_RESULTS-1:0]     res;
    logic [CNT_BITS-1:0]        count;
    logic [POSITION_BITS-1:0]   line;
    logic [POSITION_BITS-1:0]   col;
  } batch_t;

  function automatic logic is_digit(input logic [7:0] ch);
    return (ch >= 8'h30) && (ch <= 8'h39);
  endfunction

  function automatic logic is_delim(input logic [7:0] ch);
    return ch == 8'h00 || ch == 8'h20 || ch == 8'h09 || ch == 8'h0D || ch == 8'h0A ||
           ch == 8'h7B || ch == 8'h7D || ch == 8'h5B || ch == 8'h5D || ch == 8'h3A ||
           ch == 8'h2C;
  endfunction

  // Keyword table: select, index -> char
  function automatic logic [7:0] kw_char(input logic [1:0] sel, input logic [2:0] idx);
    logic [7:0] c;
    c = 8'h00;
    case (sel)
      2'd0: case (idx)
          3'd0: c = "t"; 3'd1: c = "r"; 3'd2: c = "u"; 3'd3: c = "e";
          default: c = 8'h00;
        endcase
      2'd1: case (idx)
          3'd0: c = "f"; 3'd1: c = "a"; 3'd2: c = "l"; 3'd3: c = "s"; 3'd4: c = "e";
          default: c = 8'h00;
        endcase
      default: case (idx)
          3'd0: c = "n"; 3'd1: c = "u"; 3'd2: c = "l"; 3'd3: c = "l";
          default: c = 8'h00;
        endcase
    endcase
    return c;
  endfunction

  function automatic logic [2:0] kw_len(input logic [1:0] sel);
    return (sel == 2'd1) ? 3'd5 : 3'd4;
  endfunction

  function automatic logic [3:0] kw_kind(input logic [1:0] sel);
    logic [3:0] k;
    case (sel)
      2'd0: k = K_TRUE;
      2'd1: k = K_FALSE;
      default: k = K_NULL;
    endcase
    return k;
  endfunction

  function automatic res_t mk(input logic [3:0] kind, input logic has, input logic [7:0] b,
                              input logic done);
    res_t r;
    r.kind = kind; r.has_byte = has; r.data = b; r.done = done;
    return r;
  endfunction

endpackage

FILE: src/json_tokenizer_top.sv
// ----------------------------------------------------------------------------
// json_tokenizer_top: streaming JSON tokenizer
// One byte in per item, token results out with line and column.
// ----------------------------------------------------------------------------
//  channel | signals                                  | direction
//  input   | in_valid, in_stall, byte_in              | byte stream in
//  output  | out_valid, out_stall, token_kind, has_byte,| results out
//          | out_byte, token_done, line_number, column_number
//
// A byte is decoded in the cycle it is accepted: one byte per cycle whenever
// the results drain as fast. A byte yields 0 to 4 results, delivered one per
// cycle from the result register while out_stall is low (several results for
// the UTF-8 expansion of a \u escape above 0x7F, for a keyword or number ended
// by a structural byte or byte zero, and for a number ended by a minus sign or
// an invalid byte).
// Reset (rst, synchronous) returns the lexer to idle at line 1, column 1.
// ----------------------------------------------------------------------------
module json_tokenizer_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  byte_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  token_kind,
  output logic        has_byte,
  output logic [7:0]  out_byte,
  output logic        token_done,
  output logic [jtok_pkg::POSITION_BITS-1:0] line_number,
  output logic [jtok_pkg::POSITION_BITS-1:0] column_number
);
  import jtok_pkg::*;

  batch_t batch;
  res_t   res;
  logic   room, take;

  // skid slot free means a new byte's results always have a place
  assign in_stall = !room;
  assign take     = in_valid && room;

  jtok_lexer u_lexer (
    .clk   (clk),
    .rst   (rst),
    .take  (take),
    .ch    (byte_in),
    .batch (batch)
  );

  jtok_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .in_load   (take),
    .in_batch  (batch),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (res),
    .out_line  (line_number),
    .out_col   (column_number)
  );

  assign token_kind = res.kind;
  assign has_byte   = res.has_byte;
  assign out_byte   = res.data;
  assign token_done = res.done;

`ifndef SYNTH
  a_done_no_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_done |-> !has_byte)
    else $error("done result carries a byte");
  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> token_kind <= K_ERROR)
    else $error("token kind out of range");
  a_err_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_kind == K_ERROR |-> token_done)
    else $error("error result not marked done");
`endif

endmodule

FILE: src/jtok_lexer.sv
// ----------------------------------------------------------------------------
// jtok_lexer: lexer state and per-byte result decode
// Holds phase, keyword and escape state plus position; turns one byte into
// up to four results combinationally.
// ----------------------------------------------------------------------------
module jtok_lexer (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  logic [7:0]          ch,
  output jtok_pkg::batch_t    batch
);
  import jtok_pkg::*;

  phase_t                    phase, phase_next;
  logic [1:0]                ksel, ksel_next;
  logic [2:0]                kmat, kmat_next;
  logic [1:0]                hcnt, hcnt_next;
  logic [15:0]               acc, acc_next;
  logic [9:0]                hsur, hsur_next;
  logic [POSITION_BITS-1:0]  line, col;

  logic [3:0]  hv;
  logic        hv_ok;
  logic [15:0] acc_new;
  logic [20:0] cp;

  always_comb begin
    hv_ok = 1'b1;
    hv    = 4'd0;
    if (ch >= "0" && ch <= "9") hv = 4'(ch - 8'h30);
    else if (ch >= "a" && ch <= "f") hv = 4'(ch - 8'h57);
    else if (ch >= "A" && ch <= "F") hv = 4'(ch - 8'h37);
    else hv_ok = 1'b0;
    acc_new = {acc[11:0], hv};
    // pair decode: 0x10000 + hi<<10 + lo
    cp = {1'b0, hsur, acc_new[9:0]} + 21'h10000;
  end

  always_comb begin
    res_t  r [MAX_RESULTS];
    logic [CNT_BITS-1:0] n;
    logic  redo, num_ok, num_end, err, is_num;
    phase_t nxt;
    logic [7:0] e;
    logic  e_ok;
    logic [20:0] v;
    logic  emit_utf;

    for (int i = 0; i < MAX_RESULTS; i++) r[i] = '0;
    n = '0;
    redo = 1'b0; num_ok = 1'b0; num_end = 1'b0; err = 1'b0; emit_utf = 1'b0;
    nxt = PH_IDLE;
    e = 8'h00; e_ok = 1'b0; v = '0;
    is_num = (phase >= PH_NUM_SIGN) && (phase <= PH_NUM_EXPDIG);
    phase_next = phase; ksel_next = ksel; kmat_next = kmat;
    hcnt_next = hcnt; acc_next = acc; hsur_next = hsur;

    case (phase)
      PH_KEYWORD: begin
        if (kmat >= kw_len(ksel)) begin
          if (is_delim(ch)) begin
            r[0] = mk(kw_kind(ksel), 1'b0, 8'h00, 1'b1); n = 3'd1; redo = 1'b1;
          end else err = 1'b1;
        end else if (ch == kw_char(ksel, kmat)) kmat_next = kmat + 3'd1;
        else err = 1'b1;
      end
      PH_STRING: begin
        if (ch == 8'h00 || ch == 8'h0A) err = 1'b1;
        else if (ch == 8'h22) begin
          r[0] = mk(K_STRING, 1'b0, 8'h00, 1'b1); n = 3'd1; phase_next = PH_IDLE;
        end else if (ch == 8'h5C) phase_next = PH_ESCAPE;
        else begin
          r[0] = mk(K_STRING, 1'b1, ch, 1'b0); n = 3'd1;
        end
      end
      PH_ESCAPE: begin
        case (ch)
          8'h22: begin e = 8'h22; e_ok = 1'b1; end
          8'h5C: begin e = 8'h5C; e_ok = 1'b1; end
          8'h2F: begin e = 8'h2F; e_ok = 1'b1; end
          "b":   begin e = 8'h08; e_ok = 1'b1; end
          "f":   begin e = 8'h0C; e_ok = 1'b1; end
          "n":   begin e = 8'h0A; e_ok = 1'b1; end
          "r":   begin e = 8'h0D; e_ok = 1'b1; end
          "t":   begin e = 8'h09; e_ok = 1'b1; end
          default: e_ok = 1'b0;
        endcase
        if (e_ok) begin
          r[0] = mk(K_STRING, 1'b1, e, 1'b0); n = 3'd1; phase_next = PH_STRING;
        end else if (ch == "u") begin
          hcnt_next = '0; acc_next = '0; phase_next = PH_HEX;
        end else err = 1'b1;
      end
      PH_HEX, PH_SURR_HEX: begin
        if (!hv_ok) err = 1'b1;
        else begin
          acc_next = acc_new;
          if (hcnt != 2'd3) hcnt_next = hcnt + 2'd1;
          else begin
            hcnt_next = '0;
            if (phase == PH_HEX) begin
              if (acc_new >= 16'hDC00 && acc_new <= 16'hDFFF) err = 1'b1;
              else if (acc_new >= 16'hD800 && acc_new <= 16'hDBFF) begin
                hsur_next = acc_new[9:0]; phase_next = PH_SURR_BSL;
              end else begin
                v = {5'd0, acc_new}; emit_utf = 1'b1; phase_next = PH_STRING;
              end
            end else if (acc_new >= 16'hDC00 && acc_new <= 16'hDFFF) begin
              v = cp; emit_utf = 1'b1; phase_next = PH_STRING;
            end else err = 1'b1;
          end
        end
      end
      PH_SURR_BSL: begin
        if (ch == 8'h5C) phase_next = PH_SURR_U; else err = 1'b1;
      end
      PH_SURR_U: begin
        if (ch == "u") begin
          hcnt_next = '0; acc_next = '0; phase_next = PH_SURR_HEX;
        end else err = 1'b1;
      end
      PH_NUM_SIGN: begin
        if (is_digit(ch)) begin num_ok = 1'b1; nxt = PH_NUM_INT; end
        else if (ch == ".") begin num_ok = 1'b1; nxt = PH_NUM_LEADDOT; end
      end
      PH_NUM_INT: begin
        if (is_digit(ch)) begin num_ok = 1'b1; nxt = PH_NUM_INT; end
        else if (ch == ".") begin num_ok = 1'b1; nxt = PH_NUM_FRAC; end
        else if (ch == "e" || ch == "E") begin num_ok = 1'b1; nxt = PH_NUM_EXP; end
        else num_end = 1'b1;
      end
      PH_NUM_LEADDOT: begin
        if (is_digit(ch)) begin num_ok = 1'b1; nxt = PH_NUM_FRAC; end
      end
      PH_NUM_FRAC: begin
        if (is_digit(ch)) begin num_ok = 1'b1; nxt = PH_NUM_FRAC; end
        else if (ch == "e" || ch == "E") begin num_ok = 1'b1; nxt = PH_NUM_EXP; end
        else num_end = 1'b1;
      end
      PH_NUM_EXP: begin
        if (is_digit(ch)) begin num_ok = 1'b1; nxt = PH_NUM_EXPDIG; end
        else if (ch == "+" || ch == "-") begin num_ok = 1'b1; nxt = PH_NUM_EXPSIGN; end
      end
      PH_NUM_EXPSIGN: begin
        if (is_digit(ch)) begin num_ok = 1'b1; nxt = PH_NUM_EXPDIG; end
      end
      PH_NUM_EXPDIG: begin
        if (is_digit(ch)) begin num_ok = 1'b1; nxt = PH_NUM_EXPDIG; end
        else num_end = 1'b1;
      end
      default: redo = 1'b1;
    endcase

    if (is_num) begin
      if (num_ok) begin
        r[0] = mk(K_NUMBER, 1'b1, ch, 1'b0); n = 3'd1; phase_next = nxt;
      end else if (num_end) begin
        r[0] = mk(K_NUMBER, 1'b0, 8'h00, 1'b1); n = 3'd1; redo = 1'b1;
      end else err = 1'b1;
    end

    if (emit_utf) begin
      if (v <= 21'h7F) begin
        r[0] = mk(K_STRING, 1'b1, v[7:0], 1'b0); n = 3'd1;
      end else if (v <= 21'h7FF) begin
        r[0] = mk(K_STRING, 1'b1, 8'hC0 | {3'd0, v[10:6]}, 1'b0);
        r[1] = mk(K_STRING, 1'b1, 8'h80 | {2'd0, v[5:0]}, 1'b0); n = 3'd2;
      end else if (v <= 21'hFFFF) begin
        r[0] = mk(K_STRING, 1'b1, 8'hE0 | {4'd0, v[15:12]}, 1'b0);
        r[1] = mk(K_STRING, 1'b1, 8'h80 | {2'd0, v[11:6]}, 1'b0);
        r[2] = mk(K_STRING, 1'b1, 8'h80 | {2'd0, v[5:0]}, 1'b0); n = 3'd3;
      end else begin
        r[0] = mk(K_STRING, 1'b1, 8'hF0 | {5'd0, v[20:18]}, 1'b0);
        r[1] = mk(K_STRING, 1'b1, 8'h80 | {2'd0, v[17:12]}, 1'b0);
        r[2] = mk(K_STRING, 1'b1, 8'h80 | {2'd0, v[11:6]}, 1'b0);
        r[3] = mk(K_STRING, 1'b1, 8'h80 | {2'd0, v[5:0]}, 1'b0); n = 3'd4;
      end
    end

    if (err) begin
      r[0] = mk(K_ERROR, 1'b0, 8'h00, 1'b1); n = 3'd1; phase_next = PH_IDLE;
    end

    // idle handling; redo always has at most one prior result in slot 0
    if (redo) begin
      phase_next = PH_IDLE;
      case (ch)
        8'h20, 8'h09, 8'h0D, 8'h0A: ;
        "{": begin r[n[1:0]] = mk(K_LBRACE,   1'b0, 8'h00, 1'b1); n = n + 3'd1; end
        "}": begin r[n[1:0]] = mk(K_RBRACE,   1'b0, 8'h00, 1'b1); n = n + 3'd1; end
        "[": begin r[n[1:0]] = mk(K_LBRACKET, 1'b0, 8'h00, 1'b1); n = n + 3'd1; end
        "]": begin r[n[1:0]] = mk(K_RBRACKET, 1'b0, 8'h00, 1'b1); n = n + 3'd1; end
        ":": begin r[n[1:0]] = mk(K_COLON,    1'b0, 8'h00, 1'b1); n = n + 3'd1; end
        ",": begin r[n[1:0]] = mk(K_COMMA,    1'b0, 8'h00, 1'b1); n = n + 3'd1; end
        8'h00: begin r[n[1:0]] = mk(K_EOF,    1'b0, 8'h00, 1'b1); n = n + 3'd1; end
        "t", "f", "n": begin
          ksel_next = (ch == "t") ? 2'd0 : (ch == "f") ? 2'd1 : 2'd2;
          kmat_next = 3'd1;
          phase_next = PH_KEYWORD;
        end
        8'h22: phase_next = PH_STRING;
        "-": begin
          r[n[1:0]] = mk(K_NUMBER, 1'b1, ch, 1'b0); n = n + 3'd1;
          phase_next = PH_NUM_SIGN;
        end
        default: begin
          if (is_digit(ch)) begin
            r[n[1:0]] = mk(K_NUMBER, 1'b1, ch, 1'b0); n = n + 3'd1;
            phase_next = PH_NUM_INT;
          end else begin
            r[n[1:0]] = mk(K_ERROR, 1'b0, 8'h00, 1'b1); n = n + 3'd1;
          end
        end
      endcase
    end

    for (int i = 0; i < MAX_RESULTS; i++) batch.res[i] = r[i];
    batch.count = n;
    batch.line  = line;
    batch.col   = col;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      ksel  <= '0;
      kmat  <= '0;
      hcnt  <= '0;
      acc   <= '0;
      hsur  <= '0;
      line  <= POSITION_BITS'(1);
      col   <= POSITION_BITS'(1);
    end else if (take) begin
      phase <= phase_next;
      ksel  <= ksel_next;
      kmat  <= kmat_next;
      hcnt  <= hcnt_next;
      acc   <= acc_next;
      hsur  <= hsur_next;
      if (ch == 8'h0A) begin
        if (line != POS_MAX) line <= line + POSITION_BITS'(1);
        col <= POSITION_BITS'(1);
      end else if (ch != 8'h00) begin
        if (col != POS_MAX) col <= col + POSITION_BITS'(1);
      end
    end
  end

endmodule

FILE: src/jtok_outbuf.sv
// ----------------------------------------------------------------------------
// jtok_outbuf: result register and serializer
// Holds one byte's batch, shifts results out one per cycle unless out_stall;
// a second batch register is skid so the lexer takes a byte while results wait.
// ----------------------------------------------------------------------------
module jtok_outbuf (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_load,
  input  jtok_pkg::batch_t in_batch,
  output logic             room,
  output logic             out_valid,
  input  logic             out_stall,
  output jtok_pkg::res_t   out_res,
  output logic [jtok_pkg::POSITION_BITS-1:0] out_line,
  output logic [jtok_pkg::POSITION_BITS-1:0] out_col
);
  import jtok_pkg::*;

  batch_t              cur, skid;
  logic [CNT_BITS-1:0] left;   // results remaining in cur
  logic [1:0]          idx;
  logic                skid_full;
  logic                pop, last;

  assign out_valid = (left != '0);
  assign out_res   = cur.res[idx];
  assign out_line  = cur.line;
  assign out_col   = cur.col;
  assign pop       = out_valid && !out_stall;
  assign last      = pop && (left == 3'd1);
  assign room      = !skid_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      left      <= '0;
      idx       <= '0;
      skid_full <= 1'b0;
    end else begin
      if ((left == '0) || last) begin
        idx <= '0;
        if (skid_full) begin
          cur <= skid; left <= skid.count;
          skid_full <= in_load && (in_batch.count != '0);
          if (in_load) skid <= in_batch;
        end else if (in_load) begin
          cur <= in_batch; left <= in_batch.count;
        end else left <= '0;
      end else begin
        if (pop) begin
          idx  <= idx + 2'd1;
          left <= left - 3'd1;
        end
        if (in_load && in_batch.count != '0) begin
          skid <= in_batch; skid_full <= 1'b1;
        end
      end
    end
  end

endmodule
